// File: sv/ringq_pkg.sv
`default_nettype none

package ringq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int DATA_BITS_DEFAULT = 32;

    localparam int OPCODE_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RESERVE = 2'd0,
        OP_PUBLISH = 2'd1,
        OP_CLAIM   = 2'd2,
        OP_RELEASE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_WRONG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_FREE      = 2'd0,
        PH_RESERVED  = 2'd1,
        PH_PUBLISHED = 2'd2,
        PH_CLAIMED   = 2'd3
    } phase_t;

    // Data store commands issued by the slot controller for one request.
    typedef struct packed {
        logic write;
        logic read;
    } mem_cmd_t;

endpackage

`default_nettype wire

// File: sv/ringq_slot_ctrl.sv
`default_nettype none

module ringq_slot_ctrl #(
    parameter int DEPTH = ringq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire ringq_pkg::opcode_t            opcode,
    input  wire logic [ringq_pkg::SLOT_W-1:0]  slot_index,
    output ringq_pkg::status_t                 status,
    output logic      [ringq_pkg::SLOT_W-1:0]  granted_slot,
    output logic                               queue_empty,
    output ringq_pkg::mem_cmd_t                cmd,
    output logic      [$clog2(DEPTH)-1:0]      wr_addr,
    output logic      [$clog2(DEPTH)-1:0]      rd_addr
);

    localparam int IDX_W = $clog2(DEPTH);

    ringq_pkg::phase_t phase_reg [DEPTH];
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;

    logic              idx_ok;
    logic [IDX_W-1:0]  idx_addr;
    logic [IDX_W-1:0]  sel_addr;
    ringq_pkg::phase_t sel_phase;
    logic              upd_en;
    ringq_pkg::phase_t upd_phase;
    ringq_pkg::phase_t tail_phase;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        advance = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign idx_ok   = 32'(slot_index) < 32'(DEPTH);
    assign idx_addr = IDX_W'(slot_index);
    assign wr_addr  = idx_addr;
    assign rd_addr  = tail_reg;

    always_comb begin
        case (opcode)
            ringq_pkg::OP_RESERVE: sel_addr = head_reg;
            ringq_pkg::OP_CLAIM:   sel_addr = tail_reg;
            default:               sel_addr = idx_addr;
        endcase
    end

    assign sel_phase = phase_reg[sel_addr];

    always_comb begin
        status       = ringq_pkg::ST_OK;
        granted_slot = '0;
        upd_en       = 1'b0;
        upd_phase    = sel_phase;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cmd          = '0;
        case (opcode)
            ringq_pkg::OP_RESERVE: begin
                if (sel_phase == ringq_pkg::PH_FREE) begin
                    upd_en       = 1'b1;
                    upd_phase    = ringq_pkg::PH_RESERVED;
                    granted_slot = ringq_pkg::SLOT_W'(head_reg);
                    head_next    = advance(head_reg);
                end else begin
                    status = ringq_pkg::ST_FULL;
                end
            end
            ringq_pkg::OP_PUBLISH: begin
                if (idx_ok && sel_phase == ringq_pkg::PH_RESERVED) begin
                    upd_en    = 1'b1;
                    upd_phase = ringq_pkg::PH_PUBLISHED;
                    cmd.write = 1'b1;
                end else begin
                    status = ringq_pkg::ST_WRONG;
                end
            end
            ringq_pkg::OP_CLAIM: begin
                if (sel_phase == ringq_pkg::PH_PUBLISHED) begin
                    upd_en       = 1'b1;
                    upd_phase    = ringq_pkg::PH_CLAIMED;
                    granted_slot = ringq_pkg::SLOT_W'(tail_reg);
                    tail_next    = advance(tail_reg);
                    cmd.read     = 1'b1;
                end else begin
                    status = ringq_pkg::ST_EMPTY;
                end
            end
            ringq_pkg::OP_RELEASE: begin
                if (idx_ok && sel_phase == ringq_pkg::PH_CLAIMED) begin
                    upd_en    = 1'b1;
                    upd_phase = ringq_pkg::PH_FREE;
                end else begin
                    status = ringq_pkg::ST_WRONG;
                end
            end
            default: begin
                status = ringq_pkg::ST_WRONG;
            end
        endcase
    end

    // The empty flag looks at the tail slot as it will be after this request,
    // so the slot being updated right now is forwarded.
    always_comb begin
        if (upd_en && sel_addr == tail_next) begin
            tail_phase = upd_phase;
        end else begin
            tail_phase = phase_reg[tail_next];
        end
        queue_empty = (tail_phase != ringq_pkg::PH_PUBLISHED);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                phase_reg[i] <= ringq_pkg::PH_FREE;
            end
            head_reg <= '0;
            tail_reg <= '0;
        end else if (fire) begin
            if (upd_en) begin
                phase_reg[sel_addr] <= upd_phase;
            end
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ringq_data_mem.sv
`default_nettype none

module ringq_data_mem #(
    parameter int DEPTH     = ringq_pkg::DEPTH_DEFAULT,
    parameter int DATA_BITS = ringq_pkg::DATA_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             fire,
    input  wire ringq_pkg::mem_cmd_t              cmd,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [ringq_pkg::PAYLOAD_W-1:0]  wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [ringq_pkg::PAYLOAD_W-1:0]  rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_reg;

    // The read register doubles as the payload part of the result register;
    // it reads zero unless the request was a successful claim.
    always_ff @(posedge aclk) begin
        if (fire && cmd.write) begin
            mem[wr_addr] <= DATA_BITS'(wr_data);
        end
        if (fire) begin
            rd_reg <= cmd.read ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = ringq_pkg::PAYLOAD_W'(rd_reg);

endmodule

`default_nettype wire

// File: sv/work_tracking_ring_queue.sv
// A request is held in the request register and its result in the result register that drives m_tdata.
// Throughput: one request per cycle unless the master side stalls; the slot phase lookup and update
// between the request register and the result register set that figure.
// Reset: aresetn is synchronous and active low; it frees every slot and clears the
// head and tail pointers. Stored payloads are not cleared.
`default_nettype none

module work_tracking_ring_queue #(
    parameter int DEPTH     = ringq_pkg::DEPTH_DEFAULT,
    parameter int DATA_BITS = ringq_pkg::DATA_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] opcode, [5:2] slot_index, [37:6] payload, [39:38] zero
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [5:2] granted_slot, [37:6] read_payload, [38] queue_empty,
    // [39] zero
    output logic      [39:0] m_tdata
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                                in_valid_reg;
    ringq_pkg::opcode_t                  opcode_reg;
    logic [ringq_pkg::SLOT_W-1:0]        slot_index_reg;
    logic [ringq_pkg::PAYLOAD_W-1:0]     payload_reg;

    logic                                out_valid_reg;
    ringq_pkg::status_t                  status_reg;
    logic [ringq_pkg::SLOT_W-1:0]        granted_reg;
    logic                                empty_reg;

    logic                                out_ready;
    logic                                fire;
    ringq_pkg::status_t                  status;
    logic [ringq_pkg::SLOT_W-1:0]        granted_slot;
    logic                                queue_empty;
    ringq_pkg::mem_cmd_t                 cmd;
    logic [IDX_W-1:0]                    wr_addr;
    logic [IDX_W-1:0]                    rd_addr;
    logic [ringq_pkg::PAYLOAD_W-1:0]     read_payload;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            opcode_reg     <= ringq_pkg::opcode_t'(s_tdata[1:0]);
            slot_index_reg <= s_tdata[5:2];
            payload_reg    <= s_tdata[37:6];
        end
    end

    ringq_slot_ctrl #(
        .DEPTH (DEPTH)
    ) u_slot_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .opcode       (opcode_reg),
        .slot_index   (slot_index_reg),
        .status       (status),
        .granted_slot (granted_slot),
        .queue_empty  (queue_empty),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    ringq_data_mem #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_data_mem (
        .aclk    (aclk),
        .fire    (fire),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .wr_data (payload_reg),
        .rd_addr (rd_addr),
        .rd_data (read_payload)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg  <= status;
            granted_reg <= granted_slot;
            empty_reg   <= queue_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, empty_reg, read_payload, granted_reg, status_reg};

endmodule

`default_nettype wire

// File: tb/tb_work_tracking_ring_queue.sv
`default_nettype none

module tb_work_tracking_ring_queue;

    localparam int SLOTS           = ringq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_REQUESTS = 700;
    localparam int HOLD_AT         = 560;
    localparam int HOLD_CYCLES     = 80;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [ringq_pkg::PAYLOAD_W-1:0] payload;
        logic [ringq_pkg::SLOT_W-1:0]    slot;
        ringq_pkg::opcode_t              op;
    } ring_req_t;

    typedef struct packed {
        logic                            queue_empty;
        logic [ringq_pkg::PAYLOAD_W-1:0] read_payload;
        logic [ringq_pkg::SLOT_W-1:0]    granted_slot;
        ringq_pkg::status_t              status;
    } ring_result_t;

    typedef struct packed {
        logic [SLOTS-1:0][1:0]                      phase;
        logic [SLOTS-1:0][ringq_pkg::PAYLOAD_W-1:0] payload_mem;
        logic [ringq_pkg::SLOT_W-1:0]               head;
        logic [ringq_pkg::SLOT_W-1:0]               tail;
    } ring_state_t;

    typedef struct packed {
        ring_state_t  st;
        ring_result_t res;
    } ring_step_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [1:0] opcode, [5:2] slot_index, [37:6] payload, [39:38] zero
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] status, [5:2] granted_slot, [37:6] read_payload, [38] queue_empty, [39] zero
    logic [39:0] m_tdata;

    ring_req_t    queued_requests[$];
    ring_result_t due_results[$];
    ring_state_t  plan_state  = '0;
    ring_state_t  model_state = '0;
    int           total_requests = 0;
    int           reqs_accepted  = 0;
    int           mismatches     = 0;
    int           idle_cycles    = 0;
    int           hold_left      = 0;
    bit           hold_done      = 1'b0;
    logic         req_fire       = 1'b0;

    work_tracking_ring_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Next ring state and the result of one request. With sixteen slots the
    // pointers wrap on their own.
    function automatic ring_step_t next_ring(ring_state_t cur, ring_req_t rq);
        ring_step_t nx;
        nx.st  = cur;
        nx.res = '0;
        case (rq.op)
            ringq_pkg::OP_RESERVE: begin
                if (cur.phase[cur.head] == ringq_pkg::PH_FREE) begin
                    nx.st.phase[cur.head] = ringq_pkg::PH_RESERVED;
                    nx.res.granted_slot   = cur.head;
                    nx.st.head            = cur.head + 4'd1;
                end else begin
                    nx.res.status = ringq_pkg::ST_FULL;
                end
            end
            ringq_pkg::OP_PUBLISH: begin
                if (cur.phase[rq.slot] == ringq_pkg::PH_RESERVED) begin
                    nx.st.phase[rq.slot]       = ringq_pkg::PH_PUBLISHED;
                    nx.st.payload_mem[rq.slot] = rq.payload;
                end else begin
                    nx.res.status = ringq_pkg::ST_WRONG;
                end
            end
            ringq_pkg::OP_CLAIM: begin
                if (cur.phase[cur.tail] == ringq_pkg::PH_PUBLISHED) begin
                    nx.st.phase[cur.tail] = ringq_pkg::PH_CLAIMED;
                    nx.res.granted_slot   = cur.tail;
                    nx.res.read_payload   = cur.payload_mem[cur.tail];
                    nx.st.tail            = cur.tail + 4'd1;
                end else begin
                    nx.res.status = ringq_pkg::ST_EMPTY;
                end
            end
            default: begin
                if (cur.phase[rq.slot] == ringq_pkg::PH_CLAIMED) begin
                    nx.st.phase[rq.slot] = ringq_pkg::PH_FREE;
                end else begin
                    nx.res.status = ringq_pkg::ST_WRONG;
                end
            end
        endcase
        nx.res.queue_empty = (nx.st.phase[nx.st.tail] != ringq_pkg::PH_PUBLISHED);
        return nx;
    endfunction

    // The generator tracks the ring itself so that publish and release can
    // name slots that are really reserved or claimed.
    task automatic queue_request(ringq_pkg::opcode_t op, logic [ringq_pkg::SLOT_W-1:0] slot,
                                 logic [ringq_pkg::PAYLOAD_W-1:0] data);
        ring_req_t  rq;
        ring_step_t nx;
        rq.op      = op;
        rq.slot    = slot;
        rq.payload = data;
        nx         = next_ring(plan_state, rq);
        plan_state = nx.st;
        queued_requests.push_back(rq);
    endtask

    task automatic report_failure(string msg);
        mismatches++;
        $display("error at %0t: %s", $time, msg);
    endtask

    function automatic int idle_percent(bit rx_side);
        if (reqs_accepted < 240) begin
            return rx_side ? 83 : 19;
        end
        if (reqs_accepted < 480) begin
            return rx_side ? 19 : 83;
        end
        return 0;
    endfunction

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || req_fire)) begin
            if (queued_requests.size() > 0 && $urandom_range(99) >= idle_percent(1'b0)) begin
                s_tdata  <= {2'b00, queued_requests.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && reqs_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_percent(1'b1));
            end
        end
    end

    always @(posedge aclk) begin
        ring_req_t    rq;
        ring_step_t   nx;
        ring_result_t got;
        ring_result_t want;
        if (aresetn) begin
            req_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                rq          = s_tdata[37:0];
                nx          = next_ring(model_state, rq);
                model_state = nx.st;
                due_results.push_back(nx.res);
                reqs_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[38:0];
                if (due_results.size() == 0) begin
                    report_failure($sformatf("result %0h with no request pending", m_tdata));
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status) begin
                        report_failure($sformatf("status %0d, expected %0d",
                                                 got.status, want.status));
                    end
                    if (got.granted_slot !== want.granted_slot) begin
                        report_failure($sformatf("granted_slot %0d, expected %0d",
                                                 got.granted_slot, want.granted_slot));
                    end
                    if (got.read_payload !== want.read_payload) begin
                        report_failure($sformatf("read_payload %0h, expected %0h",
                                                 got.read_payload, want.read_payload));
                    end
                    if (got.queue_empty !== want.queue_empty) begin
                        report_failure($sformatf("queue_empty %0b, expected %0b",
                                                 got.queue_empty, want.queue_empty));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int                           produced;
        int                           roll;
        int                           tries;
        int                           s;
        bit                           filling;
        logic [ringq_pkg::SLOT_W-1:0] slot;
        ringq_pkg::opcode_t           op;
        ringq_pkg::opcode_t           moves[$];
        logic [ringq_pkg::SLOT_W-1:0] reserved_slots[$];
        logic [ringq_pkg::SLOT_W-1:0] claimed_slots[$];

        // Directed requests: empty claim, wrong-state publish and release,
        // a full round trip, then a wrap of the head into a full ring.
        queue_request(ringq_pkg::OP_CLAIM, 4'd0, 32'h0);
        queue_request(ringq_pkg::OP_RELEASE, 4'd15, 32'h0);
        queue_request(ringq_pkg::OP_PUBLISH, 4'd0, 32'h1234_5678);
        queue_request(ringq_pkg::OP_RESERVE, 4'd9, 32'hFFFF_FFFF);
        queue_request(ringq_pkg::OP_PUBLISH, 4'd0, 32'hFFFF_FFFF);
        queue_request(ringq_pkg::OP_CLAIM, 4'd7, 32'hFFFF_FFFF);
        queue_request(ringq_pkg::OP_RELEASE, 4'd0, 32'h0);
        repeat (SLOTS) begin
            queue_request(ringq_pkg::OP_RESERVE, 4'($urandom_range(15)), 32'($urandom()));
        end
        queue_request(ringq_pkg::OP_RESERVE, 4'd3, 32'h0);
        queue_request(ringq_pkg::OP_PUBLISH, 4'd1, 32'h0);

        filling = 1'b0;
        for (produced = 0; produced < RANDOM_REQUESTS; produced++) begin
            // Every forty requests, pick at random a stretch that favors producers or consumers
            // so the ring runs both full and empty.
            if (produced % 40 == 0) begin
                filling = $urandom_range(1) != 0;
            end
            reserved_slots.delete();
            claimed_slots.delete();
            for (s = 0; s < SLOTS; s++) begin
                if (plan_state.phase[s] == ringq_pkg::PH_RESERVED) begin
                    reserved_slots.push_back(4'(s));
                end
                if (plan_state.phase[s] == ringq_pkg::PH_CLAIMED) begin
                    claimed_slots.push_back(4'(s));
                end
            end
            slot = 4'($urandom_range(15));
            roll = $urandom_range(99);
            if (roll < 75) begin
                moves.delete();
                if (plan_state.phase[plan_state.head] == ringq_pkg::PH_FREE) begin
                    moves.push_back(ringq_pkg::OP_RESERVE);
                    if (filling) moves.push_back(ringq_pkg::OP_RESERVE);
                end
                if (reserved_slots.size() > 0) begin
                    moves.push_back(ringq_pkg::OP_PUBLISH);
                    if (filling) moves.push_back(ringq_pkg::OP_PUBLISH);
                end
                if (plan_state.phase[plan_state.tail] == ringq_pkg::PH_PUBLISHED) begin
                    moves.push_back(ringq_pkg::OP_CLAIM);
                    if (!filling) moves.push_back(ringq_pkg::OP_CLAIM);
                end
                if (claimed_slots.size() > 0) begin
                    moves.push_back(ringq_pkg::OP_RELEASE);
                    if (!filling) moves.push_back(ringq_pkg::OP_RELEASE);
                end
                if (moves.size() == 0) begin
                    moves.push_back(ringq_pkg::OP_RESERVE);
                end
                op = moves[$urandom_range(moves.size() - 1)];
                if (op == ringq_pkg::OP_PUBLISH) begin
                    slot = reserved_slots[$urandom_range(reserved_slots.size() - 1)];
                end else if (op == ringq_pkg::OP_RELEASE) begin
                    slot = claimed_slots[$urandom_range(claimed_slots.size() - 1)];
                end
            end else if (roll < 88) begin
                op = ringq_pkg::opcode_t'(2'($urandom_range(3)));
            end else begin
                // Publish or release aimed at a slot in the wrong phase.
                op = ($urandom_range(1) != 0) ? ringq_pkg::OP_PUBLISH : ringq_pkg::OP_RELEASE;
                tries = 0;
                while (tries < 16 &&
                       plan_state.phase[slot] ==
                       ((op == ringq_pkg::OP_PUBLISH) ? ringq_pkg::PH_RESERVED
                                                      : ringq_pkg::PH_CLAIMED)) begin
                    slot = 4'($urandom_range(15));
                    tries++;
                end
            end
            queue_request(op, slot, 32'($urandom()));
        end
        total_requests = queued_requests.size();

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        while (reqs_accepted < total_requests || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/ringq_pkg.sv
sv/ringq_slot_ctrl.sv
sv/ringq_data_mem.sv
sv/work_tracking_ring_queue.sv
tb/tb_work_tracking_ring_queue.sv
